[design/epsc_pkg.sv]
// Constants and small tables for the epoch seconds to calendar converter.
// Holds the fixed-point reciprocals used for division by constants.
// Depends on nothing; imported by every module of the block but epsc_checker.
`default_nettype none

package epsc_pkg;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;
    localparam logic [15:0] DAYS_PER_WEEK = 16'd7;
    localparam logic [15:0] WDAY_OFFSET   = 16'd4;

    localparam logic [19:0] SHIFT_DAYS    = 20'd719468;
    localparam logic [19:0] ERA4_START    = 20'd584388;
    localparam logic [19:0] ERA5_START    = 20'd730485;
    localparam logic [17:0] DAYS_PER_CENT = 18'd36524;
    localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
    localparam logic [17:0] DAYS_PER_YEAR = 18'd365;

    localparam logic [11:0] YEAR_ERA4     = 12'd1600;
    localparam logic [11:0] YEAR_ERA5     = 12'd2000;
    localparam logic [11:0] YEAR_BASE     = 12'd1900;

    // Reciprocals: q = (x * RECIP) >> SHIFT, exact over the operand range used.
    localparam int unsigned DAY_SHIFT  = 35;
    localparam logic [25:0] DAY_RECIP  = 26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
    localparam int unsigned HOUR_SHIFT = 21;
    localparam logic [13:0] HOUR_RECIP = 14'(((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225);
    localparam int unsigned MIN_SHIFT  = 14;
    localparam logic [10:0] MIN_RECIP  = 11'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);
    localparam int unsigned WEEK_SHIFT = 19;
    localparam logic [16:0] WEEK_RECIP = 17'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);
    localparam int unsigned QUAD_SHIFT = 25;
    localparam logic [16:0] QUAD_RECIP = 17'(((64'd1 << QUAD_SHIFT) + 64'd364) / 64'd365);
    localparam int unsigned YEAR_SHIFT = 27;
    localparam logic [18:0] YEAR_RECIP = 19'(((64'd1 << YEAR_SHIFT) + 64'd364) / 64'd365);
    localparam int unsigned MP_SHIFT   = 19;
    localparam logic [11:0] MP_RECIP   = 12'(((64'd1 << MP_SHIFT) + 64'd152) / 64'd153);

    // First day of each March-based month within the year.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[design/epoch_seconds_to_calendar_unit.sv]
// Top level of the epoch seconds to calendar converter.
// Instantiates epsc_split, epsc_clock and epsc_date; uses epsc_pkg.
//
// Usage:
//   A word is offered on i_epoch_seconds with start high; it is taken at
//   every rising edge where start is high and busy is low. busy is always
//   low, so a new word may be taken in every cycle.
//   Each taken word gives one result word: o_done is high
//   for exactly one cycle and the calendar fields are valid in that cycle.
//   Results leave in the order the words were taken.
//   The date path sets the depth: two stages split seconds into days,
//   then seven stages for era, year of era, day of year and month.
//   Throughput is one word per cycle.
//   The receiver cannot hold results off; none is needed since the
//   pipeline never stalls.
//   A synchronous reset on i_rst_n clears all words in flight; no o_done
//   follows for them.
`default_nettype none

module epoch_seconds_to_calendar_unit import epsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_done,
    output logic [7:0]  o_year_offset,
    output logic [3:0]  o_month_index,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour_of_day,
    output logic [5:0]  o_minute_of_hour,
    output logic [5:0]  o_second_of_minute,
    output logic [2:0]  o_weekday
);

    localparam int unsigned LATENCY = 9;

    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] n_vld;
    logic [15:0]        days;
    logic [16:0]        tod;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[LATENCY-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_done = r_vld[LATENCY-1];

    epsc_split u_split (
        .i_clk  (i_clk),
        .i_secs (i_epoch_seconds),
        .o_days (days),
        .o_tod  (tod)
    );

    epsc_clock u_clock (
        .i_clk     (i_clk),
        .i_days    (days),
        .i_tod     (tod),
        .o_hour    (o_hour_of_day),
        .o_minute  (o_minute_of_hour),
        .o_second  (o_second_of_minute),
        .o_weekday (o_weekday)
    );

    epsc_date u_date (
        .i_clk          (i_clk),
        .i_days         (days),
        .o_year_offset  (o_year_offset),
        .o_month_index  (o_month_index),
        .o_day_of_month (o_day_of_month)
    );

endmodule

`default_nettype wire

[design/epsc_split.sv]
// Splits the seconds count into whole days and seconds within the day.
// Two register stages: reciprocal product, then quotient and remainder.
// Depends on epsc_pkg.
`default_nettype none

module epsc_split import epsc_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_secs,
    output logic [15:0] o_days,
    output logic [16:0] o_tod
);

    logic [50:0] r_prod;
    logic [50:0] n_prod;
    logic [31:0] r_secs;
    logic [15:0] r_days;
    logic [15:0] n_days;
    logic [16:0] r_tod;
    logic [16:0] n_tod;

    assign n_prod = 51'(i_secs[31:7]) * 51'(DAY_RECIP);
    assign n_days = r_prod[DAY_SHIFT +: 16];
    assign n_tod  = 17'(r_secs - 32'(n_days) * SECS_PER_DAY);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_secs <= i_secs;
        r_days <= n_days;
        r_tod  <= n_tod;
    end

    assign o_days = r_days;
    assign o_tod  = r_tod;

endmodule

`default_nettype wire

[design/epsc_clock.sv]
// Time of day and weekday pipeline, seven register stages deep.
// Four working stages followed by a short delay line to meet the date path.
// Depends on epsc_pkg.
`default_nettype none

module epsc_clock import epsc_pkg::*; (
    input  logic        i_clk,
    input  logic [15:0] i_days,
    input  logic [16:0] i_tod,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [2:0]  o_weekday
);

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } t_clock;

    logic [26:0] r_ph;
    logic [26:0] n_ph;
    logic [32:0] r_pw;
    logic [32:0] n_pw;
    logic [16:0] r_tod;
    logic [15:0] r_wx;
    logic [15:0] n_wx;

    logic [4:0]  r_hour2;
    logic [4:0]  n_hour;
    logic [11:0] r_rem2;
    logic [11:0] n_rem;
    logic [2:0]  r_wday2;
    logic [2:0]  n_wday;

    logic [20:0] r_pm;
    logic [20:0] n_pm;
    logic [11:0] r_rem3;
    logic [4:0]  r_hour3;
    logic [2:0]  r_wday3;

    logic [5:0]  n_min;
    logic [5:0]  n_sec;
    t_clock      n_stage4;
    t_clock      r_dly [4];

    assign n_wx = 16'(i_days + WDAY_OFFSET);
    assign n_ph = 27'(i_tod[16:4]) * 27'(HOUR_RECIP);
    assign n_pw = 33'(n_wx) * 33'(WEEK_RECIP);

    assign n_hour = r_ph[HOUR_SHIFT +: 5];
    assign n_rem  = 12'(r_tod - 17'(n_hour) * SECS_PER_HOUR);
    assign n_wday = 3'(r_wx - 16'(r_pw[WEEK_SHIFT +: 14]) * DAYS_PER_WEEK);

    assign n_pm = 21'(r_rem2[11:2]) * 21'(MIN_RECIP);

    assign n_min = r_pm[MIN_SHIFT +: 6];
    assign n_sec = 6'(r_rem3 - 12'(n_min) * SECS_PER_MIN);

    always_comb begin
        n_stage4.hour    = r_hour3;
        n_stage4.minute  = n_min;
        n_stage4.second  = n_sec;
        n_stage4.weekday = r_wday3;
    end

    always_ff @(posedge i_clk) begin
        r_ph    <= n_ph;
        r_pw    <= n_pw;
        r_tod   <= i_tod;
        r_wx    <= n_wx;
        r_hour2 <= n_hour;
        r_rem2  <= n_rem;
        r_wday2 <= n_wday;
        r_pm    <= n_pm;
        r_rem3  <= r_rem2;
        r_hour3 <= r_hour2;
        r_wday3 <= r_wday2;
        r_dly[0] <= n_stage4;
        r_dly[1] <= r_dly[0];
        r_dly[2] <= r_dly[1];
        r_dly[3] <= r_dly[2];
    end

    assign o_hour    = r_dly[3].hour;
    assign o_minute  = r_dly[3].minute;
    assign o_second  = r_dly[3].second;
    assign o_weekday = r_dly[3].weekday;

endmodule

`default_nettype wire

[design/epsc_date.sv]
// Civil date pipeline: day count to year, month and day, seven stages deep.
// Era, day of era, year of era, day of year and month each get a stage.
// Depends on epsc_pkg.
`default_nettype none

module epsc_date import epsc_pkg::*; (
    input  logic        i_clk,
    input  logic [15:0] i_days,
    output logic [7:0]  o_year_offset,
    output logic [3:0]  o_month_index,
    output logic [4:0]  o_day_of_month
);

    logic [19:0] n_z;
    logic        n_era5;
    logic [17:0] n_doe;
    logic        r_era5_1;
    logic [17:0] r_doe1;

    logic [32:0] r_pq;
    logic [32:0] n_pq;
    logic [2:0]  r_cent;
    logic [2:0]  n_cent;
    logic        r_last;
    logic        r_era5_2;
    logic [17:0] r_doe2;

    logic [17:0] r_t;
    logic [17:0] n_t;
    logic        r_era5_3;
    logic [17:0] r_doe3;

    logic [36:0] r_py;
    logic [36:0] n_py;
    logic        r_era5_4;
    logic [17:0] r_doe4;

    logic [8:0]  n_yoe;
    logic [1:0]  n_c100;
    logic [17:0] n_base;
    logic [8:0]  r_doy5;
    logic [8:0]  n_doy;
    logic [8:0]  r_yoe5;
    logic        r_era5_5;

    logic [10:0] n_v;
    logic [22:0] r_pmp;
    logic [22:0] n_pmp;
    logic [8:0]  r_doy6;
    logic [8:0]  r_yoe6;
    logic        r_era5_6;

    logic [3:0]  n_mp;
    logic        n_wrap;
    logic [11:0] n_year;
    logic [7:0]  r_year_offset;
    logic [3:0]  r_month_index;
    logic [4:0]  r_day_of_month;

    // The 32-bit input range keeps the shifted day count in era 4 or 5.
    assign n_z    = 20'(i_days) + SHIFT_DAYS;
    assign n_era5 = (n_z >= ERA5_START);
    assign n_doe  = 18'(n_z - (n_era5 ? ERA5_START : ERA4_START));

    assign n_pq   = 33'(r_doe1[17:2]) * 33'(QUAD_RECIP);
    assign n_cent = 3'(r_doe1 >= DAYS_PER_CENT) + 3'(r_doe1 >= 18'(2 * DAYS_PER_CENT))
                  + 3'(r_doe1 >= 18'(3 * DAYS_PER_CENT)) + 3'(r_doe1 >= ERA_LAST_DAY);

    assign n_t  = 18'(r_doe2 - 18'(r_pq[QUAD_SHIFT +: 8]) + 18'(r_cent) - 18'(r_last));

    assign n_py = 37'(r_t) * 37'(YEAR_RECIP);

    assign n_yoe  = r_py[YEAR_SHIFT +: 9];
    assign n_c100 = 2'(n_yoe >= 9'd100) + 2'(n_yoe >= 9'd200) + 2'(n_yoe >= 9'd300);
    assign n_base = 18'(n_yoe) * DAYS_PER_YEAR + 18'(n_yoe[8:2]) - 18'(n_c100);
    assign n_doy  = 9'(r_doe4 - n_base);

    assign n_v   = 11'(r_doy5) * 11'd5 + 11'd2;
    assign n_pmp = 23'(n_v) * 23'(MP_RECIP);

    assign n_mp   = r_pmp[MP_SHIFT +: 4];
    assign n_wrap = (n_mp >= 4'd10);
    assign n_year = 12'(r_yoe6) + (r_era5_6 ? YEAR_ERA5 : YEAR_ERA4) + 12'(n_wrap) - YEAR_BASE;

    always_ff @(posedge i_clk) begin
        r_era5_1 <= n_era5;
        r_doe1   <= n_doe;

        r_pq     <= n_pq;
        r_cent   <= n_cent;
        r_last   <= (r_doe1 == ERA_LAST_DAY);
        r_era5_2 <= r_era5_1;
        r_doe2   <= r_doe1;

        r_t      <= n_t;
        r_era5_3 <= r_era5_2;
        r_doe3   <= r_doe2;

        r_py     <= n_py;
        r_era5_4 <= r_era5_3;
        r_doe4   <= r_doe3;

        r_doy5   <= n_doy;
        r_yoe5   <= n_yoe;
        r_era5_5 <= r_era5_4;

        r_pmp    <= n_pmp;
        r_doy6   <= r_doy5;
        r_yoe6   <= r_yoe5;
        r_era5_6 <= r_era5_5;

        r_year_offset  <= n_year[7:0];
        r_month_index  <= n_wrap ? 4'(n_mp - 4'd10) : 4'(n_mp + 4'd2);
        r_day_of_month <= 5'(r_doy6 - month_start(n_mp) + 9'd1);
    end

    assign o_year_offset  = r_year_offset;
    assign o_month_index  = r_month_index;
    assign o_day_of_month = r_day_of_month;

endmodule

`default_nettype wire

[design/epsc_checker.sv]
// Port-level checks for the epoch seconds to calendar converter.
// Bound to epoch_seconds_to_calendar_unit; depends on no package.
`default_nettype none

module epsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [7:0]  o_year_offset,
    input logic [3:0]  o_month_index,
    input logic [4:0]  o_day_of_month,
    input logic [4:0]  o_hour_of_day,
    input logic [5:0]  o_minute_of_hour,
    input logic [5:0]  o_second_of_minute,
    input logic [2:0]  o_weekday
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##9 o_done)
        else $error("result word missing nine cycles after start");

    a_done_caused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 9))
        else $error("result word without a start");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_month_index <= 4'd11 && o_day_of_month >= 5'd1
                    && o_year_offset >= 8'd70 && o_year_offset <= 8'd206))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hour_of_day <= 5'd23 && o_minute_of_hour <= 6'd59
                    && o_second_of_minute <= 6'd59 && o_weekday <= 3'd6))
        else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar_unit epsc_checker u_chk (.*);

`default_nettype wire
